/* hw/rtl/srd_pkg.sv */
// shared types and constants for the sound region detector
// no dependencies

package srd_pkg;

  localparam int IndexBits  = 24;
  localparam int SampleBits = 16;
  localparam int ThreshBits = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 24;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef logic [IndexBits-1:0]  idx_t;
  typedef logic [ThreshBits-1:0] thresh_t;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgNoiseThreshold = cfg_idx_t'(0);
  localparam cfg_idx_t CfgMergeGap       = cfg_idx_t'(1);

  localparam thresh_t NoiseThresholdRst = thresh_t'(400);
  localparam idx_t    MergeGapRst       = idx_t'(10000);

  typedef struct packed {
    idx_t start;
    idx_t stop;
    logic valid;
    logic eos;
  } result_t;

endpackage

/* hw/rtl/sound_region_detector_top.sv */
// sound region detector top level: threshold detection, region grouping, result queue
// depends on srd_pkg

// One audio sample is taken per cycle and processed in the cycle it is accepted;
// the result requests it causes, at most two, are written into a four-entry result
// queue that drives the output channel. The input is ready while the queue has
// at least two free entries, so with a consumer that takes one result per cycle
// the block sustains one sample per cycle; the queue depth sets how many cycles
// of output stall are absorbed before the input stalls. Configuration writes are
// always accepted.
module sound_region_detector_top import srd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  last_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IndexBits-1:0]  group_start_o,
  output logic [IndexBits-1:0]  group_end_o,
  output logic                  group_valid_o,
  output logic                  end_of_stream_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  thresh_t thresh_q;
  idx_t    gap_q;

  idx_t    sample_index_q, sample_index_d;
  logic    in_sound_q, in_sound_d;
  idx_t    raw_start_q, raw_start_d;
  idx_t    prev_end_q, prev_end_d;
  idx_t    grp_start_q, grp_start_d;
  logic    any_seen_q, any_seen_d;

  result_t                queue_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q;

  logic                   accept, pop;
  logic [SampleBits:0]    mag;
  logic                   loud, starts, close_quiet, close_last, do_close, split;
  idx_t                   close_end, close_start;
  logic [IndexBits:0]     gap_limit;
  logic                   any_after;
  idx_t                   grp_after;
  result_t                r_split, r_final, r_first;
  logic [1:0]             push_cnt;

  assign cfg_ready_o = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= NoiseThresholdRst;
      gap_q    <= MergeGapRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgNoiseThreshold: thresh_q <= cfg_data_i[ThreshBits-1:0];
        CfgMergeGap:       gap_q    <= cfg_data_i[IndexBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (count_q <= (QueuePtrW+1)'(QueueDepth - 2));
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop        = out_valid_o && out_ready_i;

  // sample magnitude, most negative sample gives 32768
  always_comb begin
    if (sample_i[SampleBits-1]) begin
      mag = (SampleBits+1)'(0) - {1'b1, sample_i};
    end else begin
      mag = {1'b0, sample_i};
    end
  end

  assign loud        = mag > {1'b0, thresh_q};
  assign starts      = loud && !in_sound_q;
  assign close_quiet = !loud && in_sound_q;
  assign close_last  = last_sample_i && loud;
  assign do_close    = close_quiet || close_last;
  assign close_end   = close_quiet ? sample_index_q - idx_t'(1) : sample_index_q;
  assign close_start = starts ? sample_index_q : raw_start_q;
  assign gap_limit   = {1'b0, prev_end_q} + {1'b0, gap_q};
  assign split       = do_close && any_seen_q && ({1'b0, close_end} > gap_limit);
  assign any_after   = any_seen_q || do_close;

  always_comb begin
    grp_after = grp_start_q;
    if (do_close && (!any_seen_q || split)) begin
      grp_after = close_start;
    end
  end

  always_comb begin
    r_split = '{start: grp_start_q, stop: prev_end_q, valid: 1'b1, eos: 1'b0};
    if (any_after) begin
      r_final = '{start: grp_after, stop: do_close ? close_end : prev_end_q,
                  valid: 1'b1, eos: 1'b1};
    end else begin
      r_final = '{start: '0, stop: '0, valid: 1'b0, eos: 1'b1};
    end
    r_first  = split ? r_split : r_final;
    push_cnt = accept ? ({1'b0, split} + {1'b0, last_sample_i}) : 2'd0;
  end

  always_comb begin
    sample_index_d = sample_index_q;
    in_sound_d     = in_sound_q;
    raw_start_d    = raw_start_q;
    prev_end_d     = prev_end_q;
    grp_start_d    = grp_start_q;
    any_seen_d     = any_seen_q;
    if (accept) begin
      if (last_sample_i) begin
        sample_index_d = '0;
        in_sound_d     = 1'b0;
        raw_start_d    = '0;
        prev_end_d     = '0;
        grp_start_d    = '0;
        any_seen_d     = 1'b0;
      end else begin
        sample_index_d = sample_index_q + idx_t'(1);
        in_sound_d     = loud;
        raw_start_d    = close_start;
        grp_start_d    = grp_after;
        any_seen_d     = any_after;
        if (do_close) begin
          prev_end_d = close_end;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      in_sound_q     <= 1'b0;
      raw_start_q    <= '0;
      prev_end_q     <= '0;
      grp_start_q    <= '0;
      any_seen_q     <= 1'b0;
    end else begin
      sample_index_q <= sample_index_d;
      in_sound_q     <= in_sound_d;
      raw_start_q    <= raw_start_d;
      prev_end_q     <= prev_end_d;
      grp_start_q    <= grp_start_d;
      any_seen_q     <= any_seen_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      queue_q[wr_ptr_q] <= r_first;
    end
    if (push_cnt == 2'd2) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= r_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push_cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_q + (QueuePtrW+1)'(push_cnt) - (QueuePtrW+1)'(pop);
    end
  end

  assign group_start_o   = queue_q[rd_ptr_q].start;
  assign group_end_o     = queue_q[rd_ptr_q].stop;
  assign group_valid_o   = queue_q[rd_ptr_q].valid;
  assign end_of_stream_o = queue_q[rd_ptr_q].eos;

endmodule

/* hw/rtl/srd_checker.sv */
// port-level checks for the sound region detector, bound to the top level
// depends on srd_pkg and sound_region_detector_top

module srd_checker import srd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [IndexBits-1:0] group_start_i,
  input logic [IndexBits-1:0] group_end_i,
  input logic                 group_valid_i,
  input logic                 end_of_stream_i
);

  // a held result request stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  // a held result request keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(group_start_i) && $stable(group_end_i)
      && $stable(group_valid_i) && $stable(end_of_stream_i))
    else $error("result payload changed while stalled");

  // an empty stream result closes the stream
  a_empty_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !group_valid_i |-> end_of_stream_i)
    else $error("empty result without end of stream");

  // an empty stream result carries zero indices
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !group_valid_i |-> group_start_i == '0 && group_end_i == '0)
    else $error("empty result with nonzero indices");

endmodule

bind sound_region_detector_top srd_checker u_srd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .group_start_i   (group_start_o),
  .group_end_i     (group_end_o),
  .group_valid_i   (group_valid_o),
  .end_of_stream_i (end_of_stream_o)
);

/* tb/srd_group_checker.sv */
`timescale 1ns / 1ps
// checker for the sound region detector: follows the sample, result and register requests,
// predicts every group and compares each result field by field against the oldest one due
// depends on srd_pkg

module srd_group_checker import srd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  last_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [IndexBits-1:0]  group_start_i,
  input  logic [IndexBits-1:0]  group_end_i,
  input  logic                  group_valid_i,
  input  logic                  end_of_stream_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  thresh_t threshold;
  idx_t    merge_gap;
  idx_t    sample_idx;
  logic    in_run;
  idx_t    run_start;
  idx_t    last_run_end;
  idx_t    group_first;
  logic    run_seen;
  result_t groups_due[$];
  int      slips;

  task automatic note_slip(string what);
    slips++;
    if (slips <= 10) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic queue_group(idx_t first, idx_t stop, logic real_group, logic eos);
    result_t r;
    r.start = first;
    r.stop  = stop;
    r.valid = real_group;
    r.eos   = eos;
    groups_due = {groups_due, r};
  endtask

  task automatic clear_stream();
    sample_idx   = '0;
    in_run       = 1'b0;
    run_start    = '0;
    last_run_end = '0;
    group_first  = '0;
    run_seen     = 1'b0;
  endtask

  // a run ends at stop; a run too far past the previous one closes the open group
  task automatic close_run(idx_t stop);
    if (!run_seen) begin
      group_first = run_start;
      run_seen    = 1'b1;
    end else if ({1'b0, stop} > {1'b0, last_run_end} + {1'b0, merge_gap}) begin
      queue_group(group_first, last_run_end, 1'b1, 1'b0);
      group_first = run_start;
    end
    last_run_end = stop;
    in_run       = 1'b0;
  endtask

  task automatic track_sample(logic [SampleBits-1:0] s, logic last);
    logic [SampleBits:0] mag;
    mag = s[SampleBits-1] ? (17'h1_0000 - {1'b0, s}) : {1'b0, s};
    if (mag > {1'b0, threshold}) begin
      if (!in_run) begin
        run_start = sample_idx;
        in_run    = 1'b1;
      end
    end else if (in_run) begin
      close_run(sample_idx - idx_t'(1));
    end
    if (last) begin
      if (in_run) close_run(sample_idx);
      if (run_seen) begin
        queue_group(group_first, last_run_end, 1'b1, 1'b1);
      end else begin
        queue_group('0, '0, 1'b0, 1'b1);
      end
      clear_stream();
    end else begin
      sample_idx = sample_idx + idx_t'(1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      threshold = NoiseThresholdRst;
      merge_gap = MergeGapRst;
      clear_stream();
      groups_due.delete();
      slips = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (groups_due.size() == 0) begin
          note_slip($sformatf("unexpected result start %0d end %0d valid %0b eos %0b",
                              group_start_i, group_end_i, group_valid_i, end_of_stream_i));
        end else begin
          want = groups_due.pop_front();
          if (group_start_i !== want.start || group_end_i !== want.stop ||
              group_valid_i !== want.valid || end_of_stream_i !== want.eos) begin
            note_slip($sformatf({"expected start %0d end %0d valid %0b eos %0b, ",
                                 "got start %0d end %0d valid %0b eos %0b"},
                                want.start, want.stop, want.valid, want.eos,
                                group_start_i, group_end_i, group_valid_i, end_of_stream_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgNoiseThreshold: threshold = thresh_t'(cfg_data_i);
          CfgMergeGap:       merge_gap = idx_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) track_sample(sample_i, last_sample_i);
      errors_o  <= slips;
      pending_o <= groups_due.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// top of the sound region detector testbench: clock, reset, sample streams and register writes
// depends on srd_pkg, sound_region_detector_top and srd_group_checker

module testbench;
  import srd_pkg::*;

  localparam int CycleLimit      = 400000;
  localparam int SettleCycles    = 16;
  localparam int ItemsPerSetting = 40;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [SampleBits-1:0] sample      = '0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [IndexBits-1:0]  group_start;
  logic [IndexBits-1:0]  group_end;
  logic                  group_valid;
  logic                  end_of_stream;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index   = '0;
  logic [CfgBits-1:0]    cfg_data    = '0;
  int                    errors;
  int                    pending;

  int send_idle  = 0;
  int recv_idle  = 0;
  int cur_thresh = int'(NoiseThresholdRst);
  int sent       = 0;

  sound_region_detector_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_i       (sample),
    .last_sample_i  (last_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .group_start_o  (group_start),
    .group_end_o    (group_end),
    .group_valid_o  (group_valid),
    .end_of_stream_o(end_of_stream),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  srd_group_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .sample_i       (sample),
    .last_sample_i  (last_sample),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .group_start_i  (group_start),
    .group_end_i    (group_end),
    .group_valid_i  (group_valid),
    .end_of_stream_i(end_of_stream),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // loud samples lie above the current threshold (full scale when none can), quiet ones at or below it
  function automatic logic [SampleBits-1:0] make_level(bit loud);
    int mag;
    if (loud) begin
      mag = (cur_thresh >= 32768) ? 32768 : $urandom_range(32768, cur_thresh + 1);
    end else begin
      mag = $urandom_range(cur_thresh, 0);
    end
    return SampleBits'($urandom_range(1) ? -mag : mag);
  endfunction

  task automatic send_sample(logic [SampleBits-1:0] s, logic last);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic apply_settings(int thr, int gap);
    logic took;
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cur_thresh = thr;
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? CfgNoiseThreshold : CfgMergeGap;
      cfg_data  <= (r == 0) ? CfgBits'(thr) : CfgBits'(gap);
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
    end
    cfg_valid <= 1'b0;
  endtask

  // bursts of loud and quiet samples with a little full-range noise mixed in
  task automatic run_stream(int len);
    bit                    loud_now;
    logic [SampleBits-1:0] s;
    loud_now = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0) loud_now = !loud_now;
      if ($urandom_range(19) == 0) begin
        s = SampleBits'($urandom);
      end else begin
        s = make_level(loud_now);
      end
      if ($urandom_range(49) == 0) drain_results();
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin
    int thr;
    int gap;
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stream with no sound at all
    send_sample(16'h0000, 1'b1);
    // extremes and the threshold boundary on both signs
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(SampleBits'(400), 1'b0);
    send_sample(SampleBits'(-400), 1'b0);
    send_sample(SampleBits'(-401), 1'b0);
    send_sample(16'h0000, 1'b1);
    // region opened and closed by the last sample
    send_sample(16'h0000, 1'b0);
    send_sample(SampleBits'(1000), 1'b1);

    // every gap splits; the last region splits on the last sample
    apply_settings(0, 0);
    send_sample(SampleBits'(1), 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(SampleBits'(1), 1'b0);
    send_sample(SampleBits'(1), 1'b0);
    drain_results();
    send_sample(16'h0000, 1'b0);
    send_sample(SampleBits'(-1), 1'b1);

    // nothing can be loud
    apply_settings(32768, 24'hffffff);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 18 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 18 : 0;
      for (int j = 0; j < 4; j++) begin
        k = phase * 4 + j;
        case (k % 6)
          0:       thr = 0;
          1:       thr = 32768;
          5:       thr = $urandom_range(32768, 0);
          default: thr = $urandom_range(3000, 0);
        endcase
        case (k % 4)
          0:       gap = 0;
          1:       gap = 24'hffffff;
          default: gap = $urandom_range(40, 0);
        endcase
        apply_settings(thr, gap);
        sent = 0;
        while (sent < ItemsPerSetting) run_stream($urandom_range(60, 1));
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/srd_pkg.sv
hw/rtl/sound_region_detector_top.sv
hw/rtl/srd_checker.sv
tb/srd_group_checker.sv
tb/testbench.sv
